>>> rtl/csq_pkg.sv
// Shared types and constants for the cursor sequence store.
package csq_pkg;

    localparam int OP_W     = 3;
    localparam int VAL_W    = 32;
    localparam int CNT_O_W  = 7;
    localparam int STAT_W   = 2;

    localparam logic [OP_W-1:0] OP_START   = 3'd0;
    localparam logic [OP_W-1:0] OP_ADVANCE = 3'd1;
    localparam logic [OP_W-1:0] OP_INSERT  = 3'd2;
    localparam logic [OP_W-1:0] OP_ATTACH  = 3'd3;
    localparam logic [OP_W-1:0] OP_REMOVE  = 3'd4;

    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOCUR = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_WRITE,
        S_READ,
        S_DELIVER
    } state_t;

    typedef struct packed {
        logic load;       // latch the decoded operation
        logic shift;      // run the shift sequence
        logic write_new;  // write the new value at its slot
        logic read_cur;   // read the entry under the cursor
        logic deliver;    // load the result register
    } cmd_t;

    typedef struct packed {
        logic dec_shift;   // accepted op needs entries moved
        logic dec_write;   // accepted op stores a new value
        logic shift_done;  // shift sequence drained
        logic need_write;  // latched op stores a new value
        logic out_free;    // result register can take a beat
    } stat_t;

endpackage

>>> rtl/csq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module csq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/csq_ctrl.sv
// Sequencing state machine for the cursor sequence store.
module csq_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  csq_pkg::stat_t stat,
    output csq_pkg::cmd_t  cmd
);

    csq_pkg::state_t state_reg;
    csq_pkg::state_t state_next;
    logic            accept;

    assign accept = in_valid && (state_reg == csq_pkg::S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= csq_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            csq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    priority if (stat.dec_shift)
                        state_next = csq_pkg::S_SHIFT;
                    else if (stat.dec_write)
                        state_next = csq_pkg::S_WRITE;
                    else
                        state_next = csq_pkg::S_READ;
                end
            end
            csq_pkg::S_SHIFT:
            begin
                if (stat.shift_done)
                begin
                    state_next = stat.need_write ? csq_pkg::S_WRITE : csq_pkg::S_READ;
                end
            end
            csq_pkg::S_WRITE:
            begin
                state_next = csq_pkg::S_READ;
            end
            csq_pkg::S_READ:
            begin
                state_next = csq_pkg::S_DELIVER;
            end
            csq_pkg::S_DELIVER:
            begin
                if (stat.out_free)
                begin
                    state_next = csq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = csq_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            csq_pkg::S_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = accept;
            end
            csq_pkg::S_SHIFT:
            begin
                cmd.shift = 1'b1;
            end
            csq_pkg::S_WRITE:
            begin
                cmd.write_new = 1'b1;
            end
            csq_pkg::S_READ:
            begin
                cmd.read_cur = 1'b1;
            end
            csq_pkg::S_DELIVER:
            begin
                cmd.deliver = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> rtl/csq_datapath.sv
// Count, cursor, entry store, shift sequencer and result register.
module csq_datapath #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [csq_pkg::OP_W-1:0]     op,
    input  logic [csq_pkg::VAL_W-1:0]    entry_value,
    input  csq_pkg::cmd_t                cmd,
    output csq_pkg::stat_t               stat,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [csq_pkg::VAL_W-1:0]    current_value,
    output logic                         has_current,
    output logic [csq_pkg::CNT_O_W-1:0]  item_count,
    output logic [csq_pkg::CNT_O_W-1:0]  cursor_pos,
    output logic [csq_pkg::STAT_W-1:0]   status
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam logic [CW-1:0] CAP = CW'(CAPACITY);

    logic [CW-1:0]                count_reg, count_next;
    logic [CW-1:0]                cursor_reg, cursor_next;
    logic [CW-1:0]                rem_reg, rem_next;
    logic [AW-1:0]                src_reg, src_next;
    logic                         up_reg, up_next;
    logic                         wr_pend_reg;
    logic [AW-1:0]                wr_addr_reg;
    logic [AW-1:0]                pos_reg, pos_next;
    logic                         new_wr_reg, new_wr_next;
    logic [DATA_WIDTH-1:0]        val_reg;
    logic [csq_pkg::STAT_W-1:0]   st_reg, st_next;
    logic                         out_valid_reg;

    logic [csq_pkg::VAL_W-1:0]    value_out_reg;
    logic                         has_cur_out_reg;
    logic [csq_pkg::CNT_O_W-1:0]  count_out_reg;
    logic [csq_pkg::CNT_O_W-1:0]  cursor_out_reg;
    logic [csq_pkg::STAT_W-1:0]   st_out_reg;

    logic                         cur, full;
    logic [CW-1:0]                last_idx;
    logic [CW-1:0]                pos_c;
    logic [DATA_WIDTH+csq_pkg::VAL_W-1:0] val_ext;
    logic [DATA_WIDTH+csq_pkg::VAL_W-1:0] rd_ext;
    logic [CW+csq_pkg::CNT_O_W-1:0] count_ext, cursor_ext;

    logic                         ram_we, ram_re;
    logic [AW-1:0]                ram_waddr, ram_raddr;
    logic [DATA_WIDTH-1:0]        ram_wdata, ram_rdata;
    logic                         shift_rd;
    logic                         cur_now;

    assign cur      = cursor_reg < count_reg;
    assign full     = count_reg >= CAP;
    assign last_idx = count_reg - CW'(1);
    assign val_ext  = {{DATA_WIDTH{1'b0}}, entry_value};

    // Decode of the operation being accepted
    always_comb
    begin
        count_next  = count_reg;
        cursor_next = cursor_reg;
        rem_next    = '0;
        src_next    = AW'(last_idx);
        up_next     = 1'b1;
        pos_c       = '0;
        new_wr_next = 1'b0;
        st_next     = csq_pkg::ST_DONE;
        unique case (op)
            csq_pkg::OP_START:
            begin
                cursor_next = '0;
            end
            csq_pkg::OP_ADVANCE:
            begin
                if (cur)
                    cursor_next = cursor_reg + CW'(1);
                else
                    st_next = csq_pkg::ST_NOCUR;
            end
            csq_pkg::OP_INSERT, csq_pkg::OP_ATTACH:
            begin
                if (full)
                begin
                    st_next = csq_pkg::ST_FULL;
                end
                else
                begin
                    priority if (op == csq_pkg::OP_INSERT)
                        pos_c = cur ? cursor_reg : '0;
                    else
                        pos_c = cur ? cursor_reg + CW'(1) : count_reg;
                    rem_next    = count_reg - pos_c;
                    cursor_next = pos_c;
                    count_next  = count_reg + CW'(1);
                    new_wr_next = 1'b1;
                end
            end
            csq_pkg::OP_REMOVE:
            begin
                if (cur)
                begin
                    rem_next   = last_idx - cursor_reg;
                    src_next   = AW'(cursor_reg + CW'(1));
                    up_next    = 1'b0;
                    count_next = last_idx;
                end
                else
                begin
                    st_next = csq_pkg::ST_NOCUR;
                end
            end
            default:
            begin
                st_next = csq_pkg::ST_DONE;
            end
        endcase
        pos_next = AW'(pos_c);
    end

    assign shift_rd = cmd.shift && (rem_reg != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            cursor_reg    <= '0;
            rem_reg       <= '0;
            wr_pend_reg   <= 1'b0;
            new_wr_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                count_reg  <= count_next;
                cursor_reg <= cursor_next;
                rem_reg    <= rem_next;
                new_wr_reg <= new_wr_next;
            end
            else if (shift_rd)
            begin
                rem_reg <= rem_reg - CW'(1);
            end
            wr_pend_reg <= shift_rd;
            if (cmd.deliver)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            src_reg <= src_next;
            up_reg  <= up_next;
            pos_reg <= pos_next;
            val_reg <= val_ext[DATA_WIDTH-1:0];
            st_reg  <= st_next;
        end
        else if (shift_rd)
        begin
            src_reg <= up_reg ? src_reg - AW'(1) : src_reg + AW'(1);
        end
        if (shift_rd)
        begin
            wr_addr_reg <= up_reg ? src_reg + AW'(1) : src_reg - AW'(1);
        end
        if (cmd.deliver)
        begin
            value_out_reg   <= cur_now ? rd_ext[csq_pkg::VAL_W-1:0] : '0;
            has_cur_out_reg <= cur_now;
            count_out_reg   <= count_ext[csq_pkg::CNT_O_W-1:0];
            cursor_out_reg  <= cursor_ext[csq_pkg::CNT_O_W-1:0];
            st_out_reg      <= st_reg;
        end
    end

    // Shift writes lag their reads by the wr_pend_reg register; the new value goes in afterwards
    assign ram_we    = (cmd.shift && wr_pend_reg) || cmd.write_new;
    assign ram_waddr = cmd.write_new ? pos_reg : wr_addr_reg;
    assign ram_wdata = cmd.write_new ? val_reg : ram_rdata;
    assign ram_re    = shift_rd || cmd.read_cur;
    assign ram_raddr = cmd.read_cur ? AW'(cursor_reg) : src_reg;

    csq_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    assign cur_now    = cur;
    assign rd_ext     = {{csq_pkg::VAL_W{1'b0}}, ram_rdata};
    assign count_ext  = {{csq_pkg::CNT_O_W{1'b0}}, count_reg};
    assign cursor_ext = {{csq_pkg::CNT_O_W{1'b0}}, cursor_reg};

    assign stat.dec_shift  = (rem_next != '0);
    assign stat.dec_write  = new_wr_next;
    assign stat.shift_done = (rem_reg == '0) && !wr_pend_reg;
    assign stat.need_write = new_wr_reg;
    assign stat.out_free   = !out_valid_reg || !out_stall;

    assign out_valid     = out_valid_reg;
    assign current_value = value_out_reg;
    assign has_current   = has_cur_out_reg;
    assign item_count    = count_out_reg;
    assign cursor_pos    = cursor_out_reg;
    assign status        = st_out_reg;

endmodule

>>> rtl/cursor_sequence_store_core.sv
// Top level of the cursor sequence store.
// Ordered store of up to CAPACITY values with a cursor, one operation per
// input beat and one result beat per operation. Start, advance and ops that
// change nothing go from acceptance through the read and deliver states to
// the result. Insert and attach first move any entries above the slot and
// then write the new value; remove first moves the entries that follow the
// cursor. Entries move one per cycle through the single read and single
// write port of the entry RAM. A new operation is accepted as soon as the
// previous one has its result in the output register, even while that
// result is still stalled.
module cursor_sequence_store_core #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [csq_pkg::OP_W-1:0]     op,
    input  logic [csq_pkg::VAL_W-1:0]    entry_value,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [csq_pkg::VAL_W-1:0]    current_value,
    output logic                         has_current,
    output logic [csq_pkg::CNT_O_W-1:0]  item_count,
    output logic [csq_pkg::CNT_O_W-1:0]  cursor_pos,
    output logic [csq_pkg::STAT_W-1:0]   status
);

    csq_pkg::cmd_t  cmd;
    csq_pkg::stat_t stat;

    csq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    csq_datapath #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .op            (op),
        .entry_value   (entry_value),
        .cmd           (cmd),
        .stat          (stat),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .current_value (current_value),
        .has_current   (has_current),
        .item_count    (item_count),
        .cursor_pos    (cursor_pos),
        .status        (status)
    );

endmodule
